>>> rtl/core/tfn_pkg.sv
// Shared types and widths for the triangle face normal unit.
// Used by tfn_sqrt, tfn_div and triangle_face_normal_unit; depends on nothing.
package tfn_pkg;

    localparam int IN_W   = 16;  // vertex coordinate, Q8.8
    localparam int E_W    = 17;  // edge component
    localparam int P_W    = 34;  // edge product
    localparam int N_W    = 35;  // cross product component
    localparam int M_W    = 34;  // cross product magnitude
    localparam int Q_W    = 31;  // magnitude after range reduction
    localparam int QH_W   = 15;  // high part of a reduced magnitude
    localparam int QL_W   = 16;  // low part of a reduced magnitude
    localparam int SQ_W   = 62;  // square of a reduced magnitude
    localparam int S_W    = 64;  // sum of squares
    localparam int R_W    = 32;  // integer square root
    localparam int REM_W  = 35;  // square root partial remainder
    localparam int FRAC_W = 14;  // fraction bits of the result
    localparam int NUM_W  = 46;  // dividend width
    localparam int QUO_W  = 15;  // quotient width
    localparam int OUT_W  = 16;  // result component

    localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic signed [IN_W-1:0] a_x;
        logic signed [IN_W-1:0] a_y;
        logic signed [IN_W-1:0] a_z;
        logic signed [IN_W-1:0] b_x;
        logic signed [IN_W-1:0] b_y;
        logic signed [IN_W-1:0] b_z;
        logic signed [IN_W-1:0] c_x;
        logic signed [IN_W-1:0] c_y;
        logic signed [IN_W-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } tri_out_t;

    // Per-item status carried beside the arithmetic.
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tag_t;

    typedef struct packed {
        logic [2:0][Q_W-1:0] q;
        tag_t                tag;
    } sq_side_t;

endpackage

>>> rtl/core/tfn_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on tfn_pkg for widths and the side payload type.
module tfn_sqrt import tfn_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [S_W-1:0] in_rad,
    input  sq_side_t       in_side,
    output logic           out_valid,
    output logic [R_W-1:0] out_root,
    output sq_side_t       out_side
);

    logic             valid_reg [R_W];
    logic [REM_W-1:0] rem_reg   [R_W];
    logic [R_W-1:0]   root_reg  [R_W];
    logic [S_W-1:0]   rad_reg   [R_W];
    sq_side_t         side_reg  [R_W];

    for (genvar j = 0; j < R_W; j++) begin : g_stage
        logic             valid_prev;
        logic [REM_W-1:0] rem_prev;
        logic [R_W-1:0]   root_prev;
        logic [S_W-1:0]   rad_prev;
        sq_side_t         side_prev;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             fits;

        if (j == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = in_rad;
            assign side_prev  = in_side;
        end else begin : g_next
            assign valid_prev = valid_reg[j-1];
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign rad_prev   = rad_reg[j-1];
            assign side_prev  = side_reg[j-1];
        end

        // Bring down the next two radicand bits and try root*4 + 1.
        assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[S_W-1 -: 2]};
        assign trial  = {{(REM_W-R_W-2){1'b0}}, root_prev, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg[j] <= {root_prev[R_W-2:0], fits};
                rad_reg[j]  <= {rad_prev[S_W-3:0], 2'b00};
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[R_W-1];
    assign out_root  = root_reg[R_W-1];
    assign out_side  = side_reg[R_W-1];

endmodule

>>> rtl/core/tfn_div.sv
// Pipelined restoring divider for three lanes sharing one divisor.
// Depends on tfn_pkg for widths and the tag type.
module tfn_div import tfn_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][NUM_W-1:0]   in_num,
    input  logic [R_W-1:0]          in_den,
    input  tag_t                    in_tag,
    output logic                    out_valid,
    output logic [2:0][QUO_W-1:0]   out_quo,
    output tag_t                    out_tag
);

    logic                  valid_reg [QUO_W];
    logic [R_W-1:0]        den_reg   [QUO_W];
    tag_t                  tag_reg   [QUO_W];
    logic [2:0][R_W-1:0]   rem_reg   [QUO_W];
    logic [2:0][QUO_W-1:0] low_reg   [QUO_W];
    logic [2:0][QUO_W-1:0] quo_reg   [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic                  valid_prev;
        logic [R_W-1:0]        den_prev;
        tag_t                  tag_prev;
        logic [2:0][R_W-1:0]   rem_prev;
        logic [2:0][QUO_W-1:0] low_prev;
        logic [2:0][QUO_W-1:0] quo_prev;
        logic [2:0][R_W-1:0]   rem_next;
        logic [2:0][QUO_W-1:0] low_next;
        logic [2:0][QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            // The quotient fits in QUO_W bits, so the top dividend bits
            // start below the divisor.
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_prev[l] = {{(R_W-(NUM_W-QUO_W)){1'b0}},
                                      in_num[l][NUM_W-1:QUO_W]};
                assign low_prev[l] = in_num[l][QUO_W-1:0];
            end
            assign valid_prev = in_valid;
            assign den_prev   = in_den;
            assign tag_prev   = in_tag;
            assign quo_prev   = '0;
        end else begin : g_next
            assign valid_prev = valid_reg[j-1];
            assign den_prev   = den_reg[j-1];
            assign tag_prev   = tag_reg[j-1];
            assign rem_prev   = rem_reg[j-1];
            assign low_prev   = low_reg[j-1];
            assign quo_prev   = quo_reg[j-1];
        end

        always_comb begin
            logic [R_W:0] rem_sh;
            logic [R_W:0] diff;
            logic         fits;
            for (int l = 0; l < 3; l++) begin
                rem_sh      = {rem_prev[l], low_prev[l][QUO_W-1]};
                diff        = rem_sh - {1'b0, den_prev};
                fits        = (rem_sh >= {1'b0, den_prev});
                rem_next[l] = fits ? diff[R_W-1:0] : rem_sh[R_W-1:0];
                low_next[l] = {low_prev[l][QUO_W-2:0], 1'b0};
                quo_next[l] = {quo_prev[l][QUO_W-2:0], fits};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j] <= den_prev;
                tag_reg[j] <= tag_prev;
                rem_reg[j] <= rem_next;
                low_reg[j] <= low_next;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

>>> rtl/core/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: edges, cross product,
// range reduction, sum of squares, then tfn_sqrt and tfn_div; uses tfn_pkg.
//
// Usage. Each request on the s_ channel carries one triangle (three vertices,
// signed Q8.8). Each request on the m_ channel carries its unit normal as
// three signed Q1.14 components, rounded to nearest, and a degenerate flag
// that is set, with all components zero, when the cross product is zero.
// Both channels use valid/ready; a request moves when both are high.
//
// The pipeline holds the square root (32 stages, one root bit each), the
// divider (15 stages, one quotient bit each) and ten stages for the edges,
// products, cross product, magnitudes, range reduction, partial products,
// squares, sum of squares, rounding bias and the output register.
// Throughput is one triangle per cycle while the output is not stalled:
// every stage is a register with a valid bit, and a new request may enter
// each cycle that s_ready is high.
//
// The whole pipeline advances together whenever the output register is
// empty or being read. While the receiver holds m_ready low with a result
// waiting, every stage holds its contents and s_ready is low; nothing is
// dropped or repeated. Reset (aresetn low, synchronous) clears all valid
// bits; no result is pending afterwards. The unit keeps no state between
// triangles.
module triangle_face_normal_unit import tfn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tri_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tri_out_t m_data
);

    logic en;

    // Stage 1: edges e1 = b - a and e2 = c - a.
    logic                  v1_reg;
    logic signed [E_W-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;

    // Stage 2: products of edge components, one for each term of the cross product.
    logic                  v2_reg;
    logic signed [P_W-1:0] p_reg [6];

    // Stage 3: cross product e2 x e1.
    logic                  v3_reg;
    logic signed [N_W-1:0] n_reg [3];

    // Stage 4: magnitudes and signs.
    logic                v4_reg;
    logic [2:0][M_W-1:0] m_reg;
    tag_t                tag4_reg;

    // Stage 5: shift so that every magnitude is below 2^31.
    logic     v5_reg;
    sq_side_t side5_reg;

    // Stage 6: partial products of the squares.
    logic                         v6_reg;
    sq_side_t                     side6_reg;
    logic [2:0][2*QH_W-1:0]       hh_reg;
    logic [2:0][QH_W+QL_W-1:0]    hl_reg;
    logic [2:0][2*QL_W-1:0]       ll_reg;

    // Stage 7: the squares.
    logic                  v7_reg;
    sq_side_t              side7_reg;
    logic [2:0][SQ_W-1:0]  sq_reg;

    // Stage 8: the sum of squares.
    logic           v8_reg;
    sq_side_t       side8_reg;
    logic [S_W-1:0] s_sum_reg;

    // Square root outputs.
    logic           sqrt_valid;
    logic [R_W-1:0] sqrt_root;
    sq_side_t       sqrt_side;

    // Dividend with the rounding bias.
    logic                  v9_reg;
    logic [2:0][NUM_W-1:0] num_reg;
    logic [R_W-1:0]        den_reg;
    tag_t                  tag9_reg;

    // Divider outputs.
    logic                  div_valid;
    logic [2:0][QUO_W-1:0] div_quo;
    tag_t                  div_tag;

    logic     m_valid_reg;
    tri_out_t m_data_reg;
    tri_out_t m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= sqrt_valid;
            m_valid_reg <= div_valid;
        end
    end

    // Stages 1 to 3.
    always_ff @(posedge aclk) begin
        if (en) begin
            e1x_reg <= s_data.b_x - s_data.a_x;
            e1y_reg <= s_data.b_y - s_data.a_y;
            e1z_reg <= s_data.b_z - s_data.a_z;
            e2x_reg <= s_data.c_x - s_data.a_x;
            e2y_reg <= s_data.c_y - s_data.a_y;
            e2z_reg <= s_data.c_z - s_data.a_z;

            p_reg[0] <= e2y_reg * e1z_reg;
            p_reg[1] <= e2z_reg * e1y_reg;
            p_reg[2] <= e2z_reg * e1x_reg;
            p_reg[3] <= e2x_reg * e1z_reg;
            p_reg[4] <= e2x_reg * e1y_reg;
            p_reg[5] <= e2y_reg * e1x_reg;

            n_reg[0] <= N_W'(p_reg[0]) - N_W'(p_reg[1]);
            n_reg[1] <= N_W'(p_reg[2]) - N_W'(p_reg[3]);
            n_reg[2] <= N_W'(p_reg[4]) - N_W'(p_reg[5]);
        end
    end

    // Stage 4: absolute values; the magnitude never exceeds 2^33.
    always_ff @(posedge aclk) begin
        logic signed [N_W-1:0] abs_v;
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                abs_v          = n_reg[l][N_W-1] ? -n_reg[l] : n_reg[l];
                m_reg[l]       <= abs_v[M_W-1:0];
                tag4_reg.neg[l] <= n_reg[l][N_W-1];
            end
            tag4_reg.degen <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        end
    end

    // Stage 5: the smallest right shift that brings all magnitudes below 2^31.
    always_ff @(posedge aclk) begin
        logic top3, top2, top1;
        if (en) begin
            top3 = m_reg[0][M_W-1] | m_reg[1][M_W-1] | m_reg[2][M_W-1];
            top2 = m_reg[0][M_W-2] | m_reg[1][M_W-2] | m_reg[2][M_W-2];
            top1 = m_reg[0][M_W-3] | m_reg[1][M_W-3] | m_reg[2][M_W-3];
            for (int l = 0; l < 3; l++) begin
                if (top3) begin
                    side5_reg.q[l] <= m_reg[l][M_W-1:3];
                end else if (top2) begin
                    side5_reg.q[l] <= m_reg[l][M_W-2:2];
                end else if (top1) begin
                    side5_reg.q[l] <= m_reg[l][M_W-3:1];
                end else begin
                    side5_reg.q[l] <= m_reg[l][Q_W-1:0];
                end
            end
            side5_reg.tag <= tag4_reg;
        end
    end

    // Stages 6 to 8: squares from 15-bit high and 16-bit low part products, then their sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                hh_reg[l] <= side5_reg.q[l][Q_W-1:QL_W] * side5_reg.q[l][Q_W-1:QL_W];
                hl_reg[l] <= side5_reg.q[l][Q_W-1:QL_W] * side5_reg.q[l][QL_W-1:0];
                ll_reg[l] <= side5_reg.q[l][QL_W-1:0] * side5_reg.q[l][QL_W-1:0];
                sq_reg[l] <= {hh_reg[l], {(2*QL_W){1'b0}}}
                           + SQ_W'({hl_reg[l], {(QL_W+1){1'b0}}})
                           + SQ_W'(ll_reg[l]);
            end
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
            side8_reg <= side7_reg;
            s_sum_reg <= S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
        end
    end

    tfn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_rad    (s_sum_reg),
        .in_side   (side8_reg),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    // Dividend q * 2^14 + floor(r / 2) rounds the quotient to nearest.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                num_reg[l] <= NUM_W'({sqrt_side.q[l], {FRAC_W{1'b0}}})
                            + NUM_W'(sqrt_root[R_W-1:1]);
            end
            den_reg  <= sqrt_root;
            tag9_reg <= sqrt_side.tag;
        end
    end

    tfn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v9_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_tag    (tag9_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    // Saturate to one, apply the sign, and zero out degenerate triangles.
    always_comb begin
        logic [QUO_W-1:0]        mag;
        logic [2:0][OUT_W-1:0]   comp;
        for (int l = 0; l < 3; l++) begin
            mag     = (div_quo[l] > ONE_Q14) ? ONE_Q14 : div_quo[l];
            comp[l] = div_tag.neg[l] ? -{1'b0, mag} : {1'b0, mag};
            if (div_tag.degen) begin
                comp[l] = '0;
            end
        end
        m_data_next.normal_x   = comp[0];
        m_data_next.normal_y   = comp[1];
        m_data_next.normal_z   = comp[2];
        m_data_next.degenerate = div_tag.degen;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |->
            (m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0))
        else $error("degenerate result with nonzero components");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.normal_x <= 16'sd16384 && m_data.normal_x >= -16'sd16384
                  && m_data.normal_y <= 16'sd16384 && m_data.normal_y >= -16'sd16384
                  && m_data.normal_z <= 16'sd16384 && m_data.normal_z >= -16'sd16384))
        else $error("normal component beyond one");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while the pipeline is stalled");
`endif

endmodule

>>> dv/triangle_face_normal_unit_tb.sv
// Self-checking testbench for triangle_face_normal_unit: random and directed
// triangles against a built-in fixed-point normal predictor; uses tfn_pkg.
`timescale 1ns / 1ps

module triangle_face_normal_unit_tb import tfn_pkg::*; ();

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tri_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tri_out_t m_data;

    triangle_face_normal_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Triangles waiting to be driven, and normals waiting to come back.
    tri_in_t  pending_tris[$];
    tri_out_t expected_normals[$];
    int       error_count = 0;
    bit       stimulus_done = 0;
    bit       calm_phase = 0;   // no idling near the end of the run
    bit       hold_sender = 0;  // sender pause until the pipeline drains
    bit       in_accepted = 0;  // the driven request was taken at the last rising edge
    int       send_gap = 0;
    int       recv_gap = 0;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Integer square root, bit by bit, over a 64-bit sum.
    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit normal of (c - a) x (b - a), Q1.14 rounded half away from zero.
    function automatic tri_out_t face_normal(input tri_in_t t);
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] n [3];
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] q;
        logic [15:0] f [3];
        tri_out_t o;
        int k;
        e1[0] = 64'(t.b_x) - 64'(t.a_x);
        e1[1] = 64'(t.b_y) - 64'(t.a_y);
        e1[2] = 64'(t.b_z) - 64'(t.a_z);
        e2[0] = 64'(t.c_x) - 64'(t.a_x);
        e2[1] = 64'(t.c_y) - 64'(t.a_y);
        e2[2] = 64'(t.c_z) - 64'(t.a_z);
        n[0] = e2[1] * e1[2] - e2[2] * e1[1];
        n[1] = e2[2] * e1[0] - e2[0] * e1[2];
        n[2] = e2[0] * e1[1] - e2[1] * e1[0];
        o = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
            if (m[i] > mx) mx = m[i];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 31)) k++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> k;
            s = s + m[i] * m[i];
        end
        r = root_floor(s);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 14) + (r >> 1)) / r;
            if (q > 64'd16384) q = 64'd16384;
            f[i] = n[i] < 0 ? 16'(-q) : 16'(q);
        end
        o.normal_x = f[0];
        o.normal_y = f[1];
        o.normal_z = f[2];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Remember whether the request on the bus was taken at the rising edge.
    always @(posedge aclk) begin
        in_accepted <= aresetn && s_valid && s_ready;
    end

    // Driver. Inputs change on the falling edge; valid stays up until the
    // request is taken, and idle bursts are inserted at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_accepted) begin
            // Hold the request.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid  <= 1'b0;
        end else if (!calm_phase && !hold_sender && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 12);
            s_valid  <= 1'b0;
        end else if (!hold_sender && pending_tris.size() > 0) begin
            s_data  <= pending_tris.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // The receiver stalls in bursts too.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 12);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor. Accepted input requests get their predicted normal queued,
    // and each accepted output request is checked against the oldest one.
    always @(posedge aclk) begin
        tri_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_normals.push_back(face_normal(s_data));
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = expected_normals.pop_front();
                    if (m_data.normal_x !== want.normal_x)
                        report_mismatch("normal_x", m_data.normal_x, want.normal_x);
                    if (m_data.normal_y !== want.normal_y)
                        report_mismatch("normal_y", m_data.normal_y, want.normal_y);
                    if (m_data.normal_z !== want.normal_z)
                        report_mismatch("normal_z", m_data.normal_z, want.normal_z);
                    if (m_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", m_data.degenerate, want.degenerate);
                end
            end
        end
    end

    function automatic tri_in_t make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_in_t t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
        t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
        t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
        return t;
    endfunction

    // Random triangle; the span picks small or full-range coordinates, or a
    // degenerate face, so that range reduction and small magnitudes are both
    // exercised.
    function automatic tri_in_t random_tri();
        tri_in_t t;
        logic [159:0] raw;
        int span;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        t = raw[143:0];
        span = $urandom_range(0, 3);
        if (span == 0) begin
            t.a_x = 16'(int'($urandom_range(0, 15)) - 8);
            t.a_y = 16'(int'($urandom_range(0, 15)) - 8);
            t.a_z = 16'(int'($urandom_range(0, 15)) - 8);
            t.b_x = 16'(int'($urandom_range(0, 15)) - 8);
            t.b_y = 16'(int'($urandom_range(0, 15)) - 8);
            t.b_z = 16'(int'($urandom_range(0, 15)) - 8);
            t.c_x = 16'(int'($urandom_range(0, 15)) - 8);
            t.c_y = 16'(int'($urandom_range(0, 15)) - 8);
            t.c_z = 16'(int'($urandom_range(0, 15)) - 8);
        end else if (span == 1) begin
            // Collinear points give a degenerate face.
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end
        return t;
    endfunction

    initial begin
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b0;
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: extremes, axis-aligned faces, degenerate cases.
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 256, 0, 256, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 0, 256));
        pending_tris.push_back(make_tri(1, 1, 1, 2, 2, 2, 3, 3, 3));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                        -32768, 32767, -32768));
        pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                        32767, -32768, 32767));
        pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                        32767, 32767, -32768));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 1, -1, 1, 0));
        pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, 5, 7, 9));
        pending_tris.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
        pending_tris.push_back(make_tri(32767, 0, 0, -32768, 0, 0, 0, 0, 32767));
        pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));

        // Let the pipeline drain once with the sender held off.
        hold_sender = 1'b0;
        wait (pending_tris.size() == 0 && !s_valid);
        hold_sender = 1'b1;
        wait (expected_normals.size() == 0);
        @(negedge aclk);
        hold_sender = 1'b0;

        for (int i = 0; i < 1800; i++) begin
            if (i == 1600) begin
                wait (pending_tris.size() == 0);
                calm_phase = 1'b1;
            end
            pending_tris.push_back(random_tri());
            if (pending_tris.size() > 32) wait (pending_tris.size() <= 16);
        end
        wait (pending_tris.size() == 0 && !s_valid);
        wait (expected_normals.size() == 0);
        repeat (70) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tfn_pkg.sv
rtl/core/tfn_sqrt.sv
rtl/core/tfn_div.sv
rtl/core/triangle_face_normal_unit.sv
dv/triangle_face_normal_unit_tb.sv
